/* hw/rtl/pbat_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbat_pkg: phase budget accounting table package
// Sizes, item types, command and state codes, and shared helpers.
// ----------------------------------------------------------------------------
package pbat_pkg;

    localparam int PHASES             = 8;
    localparam int UNCLASSIFIED_INDEX = 7;
    localparam int PHASE_W            = (PHASES > 1) ? $clog2(PHASES) : 1;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ATTRIB = 2'd1,
        CMD_DONATE = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_P,
        ST_CHECK,
        ST_DON_SRC,
        ST_DON_DST,
        ST_RD_P2,
        ST_LEFT,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [3:0]         phase;
        logic [3:0]         to_phase;
        logic signed [63:0] amount;
    } in_item_t;

    typedef struct packed {
        logic               applied;
        logic signed [63:0] phase_consumed;
        logic [62:0]        phase_remaining;
        logic [62:0]        total_used;
    } out_item_t;

    // one write and one read address per cycle into the phase store
    typedef struct packed {
        logic               wr_alloc;
        logic               wr_cons;
        logic [PHASE_W-1:0] wr_addr;
        logic [63:0]        wr_data;
        logic [PHASE_W-1:0] rd_addr;
    } store_ctl_t;

    // clamp a signed value at zero, keeping 63 magnitude bits
    function automatic logic [62:0] clamp63(logic signed [63:0] v);
        return v[63] ? 63'd0 : v[62:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/pbat_alu.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbat_alu: shared saturating adder
// Signed 64-bit add or subtract, saturating at the signed limits.
// ----------------------------------------------------------------------------
module pbat_alu (
    input  wire logic               sub,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic signed [63:0]      y
);

    logic signed [64:0] wide;

    always_comb begin
        wide = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
        if (wide[64] != wide[63]) begin
            y = wide[64] ? pbat_pkg::S64_MIN : pbat_pkg::S64_MAX;
        end else begin
            y = wide[63:0];
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/pbat_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pbat_store: per-phase allocation and consumed store
// One write and one registered read per cycle; valid bits give zero on reset.
// ----------------------------------------------------------------------------
module pbat_store (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pbat_pkg::store_ctl_t ctl,
    output logic signed [63:0]        rd_alloc,
    output logic signed [63:0]        rd_cons
);

    logic [63:0]                  alloc_store_reg [pbat_pkg::PHASES];
    logic [63:0]                  cons_store_reg  [pbat_pkg::PHASES];
    logic [pbat_pkg::PHASES-1:0]  alloc_vld_reg;
    logic [pbat_pkg::PHASES-1:0]  cons_vld_reg;
    logic [63:0]                  rd_alloc_reg;
    logic [63:0]                  rd_cons_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alloc_vld_reg <= '0;
            cons_vld_reg  <= '0;
        end else begin
            if (ctl.wr_alloc) begin
                alloc_vld_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.wr_cons) begin
                cons_vld_reg[ctl.wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_alloc) begin
            alloc_store_reg[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.wr_cons) begin
            cons_store_reg[ctl.wr_addr] <= ctl.wr_data;
        end
        rd_alloc_reg <= alloc_vld_reg[ctl.rd_addr] ? alloc_store_reg[ctl.rd_addr] : 64'd0;
        rd_cons_reg  <= cons_vld_reg[ctl.rd_addr]  ? cons_store_reg[ctl.rd_addr]  : 64'd0;
    end

    assign rd_alloc = rd_alloc_reg;
    assign rd_cons  = rd_cons_reg;

endmodule
`default_nettype wire

/* hw/rtl/phase_budget_accounting_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// phase_budget_accounting_table_unit: per-phase time budget table
// Load, attribute, donate and query commands over a table of phase budgets.
// ----------------------------------------------------------------------------
// Each item returns exactly one result item. An item is taken only while the
// sequencer is idle and occupies it until its result is placed on the output; a
// donation that passes its checks also goes through ST_DON_SRC, then
// ST_DON_DST if it moves budget. The order of the steps is set by the
// single read port of the phase store and the one saturating adder:
// the phase is read, updated, read back, then the total is swept over every
// phase one entry a cycle. A result still held on the output stalls the
// sequencer in ST_OUT, so the next item is not taken until it is handed over.
module phase_budget_accounting_table_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pbat_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pbat_pkg::out_item_t      m_data
);

    localparam int PW = pbat_pkg::PHASE_W;

    pbat_pkg::state_t     state_reg, state_next;
    pbat_pkg::in_item_t   item_reg, item_next;
    logic                 applied_reg, applied_next;
    logic signed [63:0]   alloc_p_reg, alloc_p_next;
    logic signed [63:0]   left_reg, left_next;
    logic signed [63:0]   moved_reg, moved_next;
    logic signed [63:0]   pc_reg, pc_next;
    logic [62:0]          pr_reg, pr_next;
    logic signed [63:0]   tot_reg, tot_next;
    logic [PW-1:0]        idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    pbat_pkg::out_item_t  m_data_reg, m_data_next;

    pbat_pkg::store_ctl_t ctl;
    logic signed [63:0]   rd_alloc, rd_cons;
    logic                 alu_sub;
    logic signed [63:0]   alu_a, alu_b, alu_y;

    logic                 p_ok, q_ok, donate_ok, out_free, last_idx;
    logic [PW-1:0]        p_addr, q_addr;
    logic signed [63:0]   moved;
    pbat_pkg::cmd_t       cmd;

    pbat_store u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .rd_alloc (rd_alloc),
        .rd_cons  (rd_cons)
    );

    pbat_alu u_alu (
        .sub (alu_sub),
        .a   (alu_a),
        .b   (alu_b),
        .y   (alu_y)
    );

    always_comb begin
        cmd       = pbat_pkg::cmd_t'(item_reg.cmd);
        p_ok      = {1'b0, item_reg.phase} < 5'(pbat_pkg::PHASES);
        q_ok      = {1'b0, item_reg.to_phase} < 5'(pbat_pkg::PHASES);
        p_addr    = item_reg.phase[PW-1:0];
        q_addr    = item_reg.to_phase[PW-1:0];
        donate_ok = (cmd == pbat_pkg::CMD_DONATE) && p_ok && q_ok &&
                    (item_reg.phase != item_reg.to_phase) && !item_reg.amount[63];
        moved     = (item_reg.amount < left_reg) ? item_reg.amount : left_reg;
        out_free  = !m_valid_reg || m_ready;
        last_idx  = idx_reg == PW'(pbat_pkg::PHASES - 1);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pbat_pkg::ST_RD_P;
                end
            end
            pbat_pkg::ST_RD_P:    state_next = pbat_pkg::ST_CHECK;
            pbat_pkg::ST_CHECK: begin
                state_next = donate_ok ? pbat_pkg::ST_DON_SRC : pbat_pkg::ST_RD_P2;
            end
            pbat_pkg::ST_DON_SRC: begin
                state_next = (moved != 64'sd0) ? pbat_pkg::ST_DON_DST : pbat_pkg::ST_RD_P2;
            end
            pbat_pkg::ST_DON_DST: state_next = pbat_pkg::ST_RD_P2;
            pbat_pkg::ST_RD_P2:   state_next = pbat_pkg::ST_LEFT;
            pbat_pkg::ST_LEFT:    state_next = pbat_pkg::ST_SUM;
            pbat_pkg::ST_SUM: begin
                if (last_idx) begin
                    state_next = pbat_pkg::ST_OUT;
                end
            end
            pbat_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = pbat_pkg::ST_IDLE;
                end
            end
            default: state_next = pbat_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        s_ready      = state_reg == pbat_pkg::ST_IDLE;
        item_next    = item_reg;
        applied_next = applied_reg;
        alloc_p_next = alloc_p_reg;
        left_next    = left_reg;
        moved_next   = moved_reg;
        pc_next      = pc_reg;
        pr_next      = pr_reg;
        tot_next     = tot_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        alu_sub      = 1'b0;
        alu_a        = rd_cons;
        alu_b        = item_reg.amount;
        ctl          = '0;
        ctl.wr_addr  = p_addr;
        ctl.rd_addr  = p_addr;

        case (state_reg)
            pbat_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next    = s_data;
                    applied_next = 1'b0;
                end
            end
            pbat_pkg::ST_CHECK: begin
                alloc_p_next = rd_alloc;
                case (cmd)
                    pbat_pkg::CMD_LOAD: begin
                        ctl.wr_alloc = p_ok;
                        ctl.wr_data  = item_reg.amount;
                        applied_next = p_ok;
                    end
                    pbat_pkg::CMD_ATTRIB: begin
                        ctl.wr_cons  = p_ok && !item_reg.amount[63];
                        ctl.wr_data  = alu_y;
                        applied_next = p_ok && !item_reg.amount[63];
                    end
                    pbat_pkg::CMD_DONATE: begin
                        alu_sub   = 1'b1;
                        alu_a     = rd_alloc;
                        alu_b     = rd_cons;
                        left_next = {1'b0, pbat_pkg::clamp63(alu_y)};
                    end
                    default: ;
                endcase
            end
            pbat_pkg::ST_DON_SRC: begin
                moved_next   = moved;
                alu_sub      = 1'b1;
                alu_a        = alloc_p_reg;
                alu_b        = moved;
                ctl.wr_alloc = moved != 64'sd0;
                ctl.wr_data  = {1'b0, pbat_pkg::clamp63(alu_y)};
                ctl.rd_addr  = q_addr;
                if (moved != 64'sd0) begin
                    applied_next = 1'b1;
                end
            end
            pbat_pkg::ST_DON_DST: begin
                alu_a        = rd_alloc;
                alu_b        = moved_reg;
                ctl.wr_alloc = 1'b1;
                ctl.wr_addr  = q_addr;
                ctl.wr_data  = alu_y;
            end
            pbat_pkg::ST_LEFT: begin
                alu_sub     = 1'b1;
                alu_a       = rd_alloc;
                alu_b       = rd_cons;
                pc_next     = p_ok ? rd_cons : 64'sd0;
                pr_next     = p_ok ? pbat_pkg::clamp63(alu_y) : 63'd0;
                tot_next    = 64'sd0;
                idx_next    = '0;
                ctl.rd_addr = '0;
            end
            pbat_pkg::ST_SUM: begin
                alu_a       = tot_reg;
                alu_b       = rd_cons;
                ctl.rd_addr = idx_reg + PW'(1);
                idx_next    = idx_reg + PW'(1);
                // the unclassified phase is left out of the total
                if (32'(idx_reg) != pbat_pkg::UNCLASSIFIED_INDEX) begin
                    tot_next = alu_y;
                end
            end
            pbat_pkg::ST_OUT: begin
                if (out_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.applied         = applied_reg;
                    m_data_next.phase_consumed  = pc_reg;
                    m_data_next.phase_remaining = pr_reg;
                    m_data_next.total_used      = pbat_pkg::clamp63(tot_reg);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pbat_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        applied_reg <= applied_next;
        alloc_p_reg <= alloc_p_next;
        left_reg    <= left_next;
        moved_reg   <= moved_next;
        pc_reg      <= pc_next;
        pr_reg      <= pr_next;
        tot_reg     <= tot_next;
        idx_reg     <= idx_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.wr_alloc && ctl.wr_cons))
        else $error("both stores written in one cycle");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pbat_pkg::ST_IDLE) |-> (!ctl.wr_alloc && !ctl.wr_cons))
        else $error("store written while idle");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == pbat_pkg::ST_OUT))
        else $error("result raised outside the output step");

    a_sweep_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pbat_pkg::ST_SUM && last_idx) |=> (state_reg == pbat_pkg::ST_OUT))
        else $error("total sweep did not finish");

endmodule
`default_nettype wire

/* tb/sv/pbat_budget_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbat_budget_checker: result checker for the phase budget accounting table
// Watches both channels, keeps its own copy of the allocation and consumed
// tables, predicts one result per accepted item and compares field by field.
// ----------------------------------------------------------------------------
module pbat_budget_checker
    import pbat_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire in_item_t   s_data,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire out_item_t  m_data,
    output int              mismatch_cnt,
    output int              results_owed
);

    logic signed [63:0] alloc_tbl [PHASES];
    logic signed [63:0] used_tbl  [PHASES];
    out_item_t          expected_results [$];

    initial begin
        mismatch_cnt = 0;
        results_owed = 0;
        for (int i = 0; i < PHASES; i++) begin
            alloc_tbl[i] = '0;
            used_tbl[i]  = '0;
        end
    end

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63])
            return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] floor0(logic signed [63:0] v);
        return v[63] ? 64'sd0 : v;
    endfunction

    function automatic logic signed [63:0] budget_left(int p);
        return floor0(sat_sub(alloc_tbl[p], used_tbl[p]));
    endfunction

    // applies one command to the shadow tables and returns the result item
    function automatic out_item_t predict_budget(in_item_t it);
        out_item_t          r;
        logic signed [63:0] amt, avail, moved, tot, left;
        logic               p_ok, q_ok;
        int                 p, q;
        r    = '0;
        amt  = it.amount;
        p    = it.phase;
        q    = it.to_phase;
        p_ok = (p < PHASES);
        q_ok = (q < PHASES);
        case (it.cmd)
            CMD_LOAD: begin
                if (p_ok) begin
                    alloc_tbl[p] = amt;
                    r.applied = 1'b1;
                end
            end
            CMD_ATTRIB: begin
                if (p_ok && amt >= 0) begin
                    used_tbl[p] = sat_add(used_tbl[p], amt);
                    r.applied = 1'b1;
                end
            end
            CMD_DONATE: begin
                if (p_ok && q_ok && p != q && amt >= 0) begin
                    avail = budget_left(p);
                    moved = (amt < avail) ? amt : avail;
                    if (moved > 0) begin
                        alloc_tbl[p] = floor0(sat_sub(alloc_tbl[p], moved));
                        alloc_tbl[q] = sat_add(alloc_tbl[q], moved);
                        r.applied = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (p_ok) begin
            left = budget_left(p);
            r.phase_consumed  = used_tbl[p];
            r.phase_remaining = left[62:0];
        end
        tot = '0;
        for (int i = 0; i < PHASES; i++) begin
            if (i != UNCLASSIFIED_INDEX)
                tot = sat_add(tot, used_tbl[i]);
        end
        tot = floor0(tot);
        r.total_used = tot[62:0];
        return r;
    endfunction

    task automatic check_field(string name, logic signed [63:0] exp_v, logic signed [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        out_item_t exp_r;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item with nothing expected");
                    mismatch_cnt++;
                end else begin
                    exp_r = expected_results.pop_front();
                    check_field("applied", exp_r.applied, m_data.applied);
                    check_field("phase_consumed", exp_r.phase_consumed, m_data.phase_consumed);
                    check_field("phase_remaining", exp_r.phase_remaining,
                                m_data.phase_remaining);
                    check_field("total_used", exp_r.total_used, m_data.total_used);
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(predict_budget(s_data));
        end
        results_owed <= expected_results.size();
    end

endmodule

/* tb/sv/phase_budget_accounting_table_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_budget_accounting_table_unit_tb: top-level bench for the budget table
// Directed corner cases then random commands under three ready/valid idling
// patterns; the checker instance predicts and compares every result item.
// ----------------------------------------------------------------------------
module phase_budget_accounting_table_unit_tb;
    import pbat_pkg::*;

    localparam int CYCLE_LIMIT    = 400_000;
    localparam int RAND_PER_PHASE = 170;
    localparam int SETTLE_CYCLES  = 40;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int mismatch_cnt;
    int results_owed;
    int cycle_cnt    = 0;
    int snd_idle_pct = 32;
    int rcv_idle_pct = 72;

    phase_budget_accounting_table_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    pbat_budget_checker u_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .mismatch_cnt (mismatch_cnt),
        .results_owed (results_owed)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready   <= ($urandom_range(99) >= rcv_idle_pct);
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic in_item_t budget_op(cmd_t c, int p, int q, logic signed [63:0] amt);
        in_item_t it;
        it.cmd      = c;
        it.phase    = 4'(p);
        it.to_phase = 4'(q);
        it.amount   = amt;
        return it;
    endfunction

    // mostly valid phases and modest amounts so the tables do not pin at the rails
    function automatic in_item_t rand_budget_op();
        in_item_t it;
        int       sel;
        it.cmd      = 2'($urandom_range(3));
        it.phase    = ($urandom_range(99) < 85) ? 4'($urandom_range(PHASES - 1))
                                                : 4'($urandom_range(15));
        it.to_phase = ($urandom_range(99) < 85) ? 4'($urandom_range(PHASES - 1))
                                                : 4'($urandom_range(15));
        sel = $urandom_range(99);
        if (sel < 55)
            it.amount = 64'($urandom_range(5000));
        else if (sel < 68)
            it.amount = 64'sd0 - 64'($urandom_range(5000));
        else if (sel < 85)
            it.amount = {$urandom, $urandom};
        else begin
            case ($urandom_range(3))
                0:       it.amount = S64_MAX;
                1:       it.amount = S64_MIN;
                2:       it.amount = S64_MAX - 64'($urandom_range(3));
                default: it.amount = '0;
            endcase
        end
        return it;
    endfunction

    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // hold the sender off until every result item has come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // fresh table, then rails and invalid phases
        send_item(budget_op(CMD_QUERY,  0, 0, 64'sd0));
        send_item(budget_op(CMD_LOAD,   0, 0, S64_MAX));
        send_item(budget_op(CMD_LOAD,   1, 0, S64_MIN));
        send_item(budget_op(CMD_LOAD,   8, 0, 64'sd100));
        // allocation at the bottom rail: remaining saturates then clamps
        send_item(budget_op(CMD_ATTRIB, 1, 0, 64'sd5));
        send_item(budget_op(CMD_ATTRIB, 0, 0, 64'sd0));
        send_item(budget_op(CMD_ATTRIB, 0, 0, -64'sd1));
        send_item(budget_op(CMD_ATTRIB, 2, 0, S64_MAX));
        send_item(budget_op(CMD_ATTRIB, 2, 0, S64_MAX));
        send_item(budget_op(CMD_ATTRIB, 3, 0, S64_MAX));
        send_item(budget_op(CMD_ATTRIB, UNCLASSIFIED_INDEX, 0, 64'sd1000));
        send_item(budget_op(CMD_ATTRIB, 15, 0, 64'sd10));
        // donations: one that moves, then each of the no-op cases
        send_item(budget_op(CMD_DONATE, 0, 4, 64'sd5));
        send_item(budget_op(CMD_DONATE, 0, 0, 64'sd5));
        send_item(budget_op(CMD_DONATE, 0, 9, 64'sd5));
        send_item(budget_op(CMD_DONATE, 12, 0, 64'sd5));
        send_item(budget_op(CMD_DONATE, 0, 4, -64'sd3));
        send_item(budget_op(CMD_DONATE, 0, 4, 64'sd0));
        send_item(budget_op(CMD_DONATE, 2, 5, 64'sd100));
        // larger than what is left: moves the remainder, destination reaches the top rail
        send_item(budget_op(CMD_DONATE, 0, 4, S64_MAX));
        send_item(budget_op(CMD_QUERY,  15, 0, 64'sd0));
        send_item(budget_op(CMD_QUERY,  4, 0, 64'sd0));
        send_item(budget_op(CMD_QUERY,  UNCLASSIFIED_INDEX, 0, 64'sd0));
        send_item(budget_op(CMD_LOAD,   0, 0, 64'sd0));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    snd_idle_pct = 32;
                    rcv_idle_pct = 72;
                end
                1: begin
                    snd_idle_pct = 72;
                    rcv_idle_pct = 32;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            repeat (RAND_PER_PHASE)
                send_item(rand_budget_op());
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_cnt == 0 && results_owed == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
